[rtl/core/qrm_pkg.sv]
// Package for the quaternion to rotation matrix block.
// Holds the widths and stage counts of the datapath; its checker shares the widths.
// Depends on nothing.
package qrm_pkg;
	localparam int IN_W   = 16;
	localparam int FRAC   = 14;
	localparam int OUT_W  = 16;
	localparam int PROD_W = 2 * IN_W;
	localparam int S_W    = PROD_W + 1;
	localparam int NUM_W  = PROD_W + 3;
	localparam int REM_W  = PROD_W + 2;
	localparam int Q_W    = FRAC + 2;
	localparam int NSTEP  = FRAC + 2;
	localparam int NLANE  = 9;
	localparam int NPROD  = 10;

	typedef logic [REM_W-1:0] rem_t;
	typedef logic [Q_W-1:0]   quo_t;
endpackage

[rtl/core/quaternion_to_rotation_matrix.sv]
// Top level of the quaternion to rotation matrix block.
// Uses qrm_pkg for widths and stage counts.
//
// The input channel (in_valid, in_stall, qw..qz) takes one quaternion per
// transfer; it need not have unit length. The output channel (out_valid,
// out_stall) gives the nine matrix entries in Q14 and a degenerate flag.
// Each entry is the exact ratio to the squared norm, rounded to nearest
// with ties away from zero and clamped to plus or minus one.
// An all-zero quaternion sets degenerate and gives zero entries.
// The pipeline has one product stage, one sum stage, sixteen restoring
// division stages that each resolve one quotient bit in nine lanes, and
// one rounding stage that is the output register.
// Throughput is one transfer per cycle. When the receiver stalls with a
// result waiting, the whole pipeline holds and in_stall is raised.
// Reset clears the valid bits only; the data registers are not reset.
module quaternion_to_rotation_matrix (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [qrm_pkg::IN_W-1:0]   qw,
	input  logic signed [qrm_pkg::IN_W-1:0]   qx,
	input  logic signed [qrm_pkg::IN_W-1:0]   qy,
	input  logic signed [qrm_pkg::IN_W-1:0]   qz,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [qrm_pkg::OUT_W-1:0]  xaxis_x,
	output logic signed [qrm_pkg::OUT_W-1:0]  xaxis_y,
	output logic signed [qrm_pkg::OUT_W-1:0]  xaxis_z,
	output logic signed [qrm_pkg::OUT_W-1:0]  yaxis_x,
	output logic signed [qrm_pkg::OUT_W-1:0]  yaxis_y,
	output logic signed [qrm_pkg::OUT_W-1:0]  yaxis_z,
	output logic signed [qrm_pkg::OUT_W-1:0]  zaxis_x,
	output logic signed [qrm_pkg::OUT_W-1:0]  zaxis_y,
	output logic signed [qrm_pkg::OUT_W-1:0]  zaxis_z,
	output logic                              degenerate
);
	logic adv;
	logic v_s1;
	logic signed [qrm_pkg::PROD_W-1:0] p_s1 [qrm_pkg::NPROD];
	logic signed [qrm_pkg::NUM_W-1:0]  num [qrm_pkg::NLANE];
	logic signed [qrm_pkg::NUM_W-1:0]  e [qrm_pkg::NPROD];
	logic [qrm_pkg::S_W-1:0]           s_sum;

	logic                    v_sd    [qrm_pkg::NSTEP+1];
	logic [qrm_pkg::S_W-1:0] s_sd    [qrm_pkg::NSTEP+1];
	logic                    zero_sd [qrm_pkg::NSTEP+1];
	logic                    neg_sd  [qrm_pkg::NSTEP+1][qrm_pkg::NLANE];
	qrm_pkg::rem_t           rem_sd  [qrm_pkg::NSTEP+1][qrm_pkg::NLANE];
	qrm_pkg::quo_t           quo_sd  [qrm_pkg::NSTEP+1][qrm_pkg::NLANE];

	logic                                    v_q;
	logic                                    deg_q;
	logic signed [qrm_pkg::OUT_W-1:0]        res_q [qrm_pkg::NLANE];
	logic signed [qrm_pkg::OUT_W-1:0]        res_d [qrm_pkg::NLANE];

	assign adv      = !(v_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= qw * qw;
			p_s1[1] <= qx * qx;
			p_s1[2] <= qy * qy;
			p_s1[3] <= qz * qz;
			p_s1[4] <= qx * qy;
			p_s1[5] <= qw * qz;
			p_s1[6] <= qx * qz;
			p_s1[7] <= qw * qy;
			p_s1[8] <= qy * qz;
			p_s1[9] <= qw * qx;
		end
	end

	always_comb begin
		for (int i = 0; i < qrm_pkg::NPROD; i++) begin
			e[i] = qrm_pkg::NUM_W'(p_s1[i]);
		end
		s_sum  = qrm_pkg::S_W'(e[0] + e[1] + e[2] + e[3]);
		num[0] = e[0] + e[1] - e[2] - e[3];
		num[1] = (e[4] + e[5]) <<< 1;
		num[2] = (e[6] - e[7]) <<< 1;
		num[3] = (e[4] - e[5]) <<< 1;
		num[4] = e[0] - e[1] + e[2] - e[3];
		num[5] = (e[8] + e[9]) <<< 1;
		num[6] = (e[6] + e[7]) <<< 1;
		num[7] = (e[8] - e[9]) <<< 1;
		num[8] = e[0] - e[1] - e[2] + e[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (adv) begin
			v_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_sd[0]    <= s_sum;
			zero_sd[0] <= (s_sum == '0);
			for (int i = 0; i < qrm_pkg::NLANE; i++) begin
				neg_sd[0][i] <= num[i][qrm_pkg::NUM_W-1];
				rem_sd[0][i] <= num[i][qrm_pkg::NUM_W-1] ? qrm_pkg::REM_W'(-num[i])
				                                         : qrm_pkg::REM_W'(num[i]);
				quo_sd[0][i] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= qrm_pkg::NSTEP; k++) begin : g_step
		qrm_pkg::rem_t t    [qrm_pkg::NLANE];
		qrm_pkg::rem_t diff [qrm_pkg::NLANE];
		logic          ge   [qrm_pkg::NLANE];

		always_comb begin
			for (int i = 0; i < qrm_pkg::NLANE; i++) begin
				t[i]    = (k == 1) ? rem_sd[k-1][i]
				                   : {rem_sd[k-1][i][qrm_pkg::REM_W-2:0], 1'b0};
				ge[i]   = (t[i] >= qrm_pkg::REM_W'(s_sd[k-1]));
				diff[i] = t[i] - qrm_pkg::REM_W'(s_sd[k-1]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (adv) begin
				v_sd[k] <= v_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				s_sd[k]    <= s_sd[k-1];
				zero_sd[k] <= zero_sd[k-1];
				for (int i = 0; i < qrm_pkg::NLANE; i++) begin
					neg_sd[k][i] <= neg_sd[k-1][i];
					rem_sd[k][i] <= ge[i] ? diff[i] : t[i];
					quo_sd[k][i] <= {quo_sd[k-1][i][qrm_pkg::Q_W-2:0], ge[i]};
				end
			end
		end
	end

	always_comb begin
		logic [qrm_pkg::Q_W:0] rq;
		logic [qrm_pkg::Q_W:0] one;
		logic [qrm_pkg::OUT_W-1:0] mag;
		one = (qrm_pkg::Q_W+1)'(1) << qrm_pkg::FRAC;
		for (int i = 0; i < qrm_pkg::NLANE; i++) begin
			rq  = ({1'b0, quo_sd[qrm_pkg::NSTEP][i]} + (qrm_pkg::Q_W+1)'(1)) >> 1;
			if (rq > one) begin
				rq = one;
			end
			mag = qrm_pkg::OUT_W'(rq);
			if (zero_sd[qrm_pkg::NSTEP]) begin
				res_d[i] = '0;
			end else if (neg_sd[qrm_pkg::NSTEP][i]) begin
				res_d[i] = -$signed(mag);
			end else begin
				res_d[i] = $signed(mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_sd[qrm_pkg::NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_q <= zero_sd[qrm_pkg::NSTEP];
			for (int i = 0; i < qrm_pkg::NLANE; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	assign out_valid  = v_q;
	assign degenerate = deg_q;
	assign xaxis_x    = res_q[0];
	assign xaxis_y    = res_q[1];
	assign xaxis_z    = res_q[2];
	assign yaxis_x    = res_q[3];
	assign yaxis_y    = res_q[4];
	assign yaxis_z    = res_q[5];
	assign zaxis_x    = res_q[6];
	assign zaxis_y    = res_q[7];
	assign zaxis_z    = res_q[8];
endmodule

[rtl/core/qrm_checker.sv]
// Port-level checker for the quaternion to rotation matrix block.
// Uses qrm_pkg for widths; bound to the top level at the end of this file.
module qrm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic signed [qrm_pkg::IN_W-1:0]   qw,
	input logic signed [qrm_pkg::IN_W-1:0]   qx,
	input logic signed [qrm_pkg::IN_W-1:0]   qy,
	input logic signed [qrm_pkg::IN_W-1:0]   qz,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [qrm_pkg::OUT_W-1:0]  xaxis_x,
	input logic signed [qrm_pkg::OUT_W-1:0]  xaxis_y,
	input logic signed [qrm_pkg::OUT_W-1:0]  xaxis_z,
	input logic signed [qrm_pkg::OUT_W-1:0]  yaxis_x,
	input logic signed [qrm_pkg::OUT_W-1:0]  yaxis_y,
	input logic signed [qrm_pkg::OUT_W-1:0]  yaxis_z,
	input logic signed [qrm_pkg::OUT_W-1:0]  zaxis_x,
	input logic signed [qrm_pkg::OUT_W-1:0]  zaxis_y,
	input logic signed [qrm_pkg::OUT_W-1:0]  zaxis_z,
	input logic                              degenerate
);
	logic signed [qrm_pkg::OUT_W-1:0] one;
	assign one = qrm_pkg::OUT_W'(1) << qrm_pkg::FRAC;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output is stalled");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> xaxis_x == 0 && xaxis_y == 0 && xaxis_z == 0 &&
			yaxis_x == 0 && yaxis_y == 0 && yaxis_z == 0 &&
			zaxis_x == 0 && zaxis_y == 0 && zaxis_z == 0)
		else $error("degenerate result with nonzero entries");

	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> xaxis_x <= one && xaxis_x >= -one && yaxis_y <= one &&
			yaxis_y >= -one && zaxis_z <= one && zaxis_z >= -one)
		else $error("diagonal entry beyond unit range");
endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);
